/* src/eev_pkg.sv */
// Shared types and constants of the EEVDF task scheduler.
// Used by eevdf_task_scheduler_unit; no dependencies.
package eev_pkg;

    typedef enum logic [2:0] {
        CMD_ADMIT, CMD_SETATTR, CMD_SLEEP, CMD_WAKE,
        CMD_YIELD, CMD_EXIT, CMD_PICK, CMD_TICK
    } t_cmd;

    typedef enum logic [1:0] {SS_FREE, SS_READY, SS_RUN, SS_SLEEP} t_sst;

    typedef enum logic [2:0] {S_IDLE, S_ACT, S_DIV, S_SCAN, S_PWB, S_DONE} t_state;

    localparam logic [1:0] RES_OK       = 2'd0;
    localparam logic [1:0] RES_NONE     = 2'd1;
    localparam logic [1:0] RES_BADSTATE = 2'd2;

    localparam logic [2:0] W_MIN = 3'd1;
    localparam logic [2:0] W_MAX = 3'd5;

    // reciprocals for exact 32-bit division by three and by five
    localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;
    localparam logic [31:0] RECIP5 = 32'hCCCCCCCD;

    typedef struct packed {
        t_sst        status;
        logic [15:0] id;
        logic [2:0]  weight;
        logic [15:0] req;
        logic [31:0] vts;
        logic [31:0] used;
        logic        chg;
        logic [7:0]  chan;
    } t_entry;

    function automatic logic [2:0] clamp_weight(logic [2:0] w);
        logic [2:0] r;
        r = w;
        if (w == 3'd0) r = W_MIN;
        else if (w > W_MAX) r = W_MAX;
        return r;
    endfunction

    function automatic logic [31:0] recip(logic [2:0] w);
        logic [31:0] r;
        case (w)
            3'd3:    r = RECIP3;
            3'd5:    r = RECIP5;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // x divided by w, p = x * recip(w)
    function automatic logic [31:0] div_w(logic [31:0] x, logic [63:0] p, logic [2:0] w);
        logic [31:0] r;
        case (w)
            3'd2:    r = x >> 1;
            3'd3:    r = 32'(p >> 33);
            3'd4:    r = x >> 2;
            3'd5:    r = 32'(p >> 34);
            default: r = x;
        endcase
        return r;
    endfunction

endpackage

/* src/eevdf_task_scheduler_unit.sv */
// EEVDF task scheduler: slot table in one RAM, command sequencer, pick pipeline.
// Depends on eev_pkg and eev_ram.
//
// channel | direction | handshake                  | payload
// in      | input     | i_in_valid / o_in_stall    | command, slot, task_id, weight,
//         |           |                            | request_len, channel
// out     | output    | o_out_valid / i_out_stall  | status, chosen_slot, chosen_id,
//         |           |                            | virtual_time_now, active_weight
// cfg     | input     | psel/penable/pwrite/pready | scale at byte address 0
//
// Admit, set attributes, sleep, yield, exit: RAM read, update, result.
// Wake, pick and tick scan every slot; tick first divides scale by the weight sum
// when that sum is nonzero. Scans read one slot per cycle via the single RAM read port.
// Reset is synchronous; slot states read as free until a slot is first written.
// A result waits in the output register while the next item is taken.
module eevdf_task_scheduler_unit
    import eev_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_command,
    input  logic [5:0]  i_slot,
    input  logic [15:0] i_task_id,
    input  logic [2:0]  i_weight,
    input  logic [15:0] i_request_len,
    input  logic [7:0]  i_channel,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [5:0]  o_chosen_slot,
    output logic [15:0] o_chosen_id,
    output logic [31:0] o_virtual_time_now,
    output logic [8:0]  o_active_weight,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = $bits(t_entry);

    t_state r_state, n_state;

    logic [15:0]      r_scale;
    logic [31:0]      r_vt;
    logic [8:0]       r_ws;
    logic [SLOTS-1:0] r_vld;

    t_cmd        r_cmd;
    logic [SW-1:0] r_slot;
    logic [15:0] r_tid;
    logic [2:0]  r_wgt;
    logic [15:0] r_req;
    logic [7:0]  r_chan;

    logic [CW-1:0] r_idx;
    logic          r_p1_v;
    logic [SW-1:0] r_p1_idx;

    logic          r_b_v;
    logic [SW-1:0] r_b_idx;
    t_entry        r_b_e;
    logic [31:0]   r_b_age, r_b_us, r_b_rs;

    logic          r_c_v;
    logic [SW-1:0] r_c_idx;
    t_entry        r_c_e;
    logic [31:0]   r_c_lag, r_c_us, r_c_rs;
    logic [63:0]   r_c_m1, r_c_m2;

    logic          r_best_f;
    logic [31:0]   r_best_dl;
    logic [SW-1:0] r_best_idx;
    t_entry        r_best_e;

    logic [15:0] r_dq;
    logic [8:0]  r_dr;
    logic [3:0]  r_dcnt;

    logic [1:0]  r_rst;
    logic [5:0]  r_rcs;
    logic [15:0] r_rcid;

    logic        r_out_valid;
    logic [1:0]  r_o_status;
    logic [5:0]  r_o_cs;
    logic [15:0] r_o_cid;
    logic [31:0] r_o_vt;
    logic [8:0]  r_o_ws;

    logic          ram_we, ram_re;
    logic [SW-1:0] ram_waddr, ram_raddr;
    t_entry        ram_wdata;
    logic [EW-1:0] ram_rdata;
    t_entry        e_rd;

    logic accept, slot_ok, issue, scan_end, act_ok, out_load, cfg_wr;
    t_sst act_st, p1_st;

    logic [34:0] b_age_full;
    logic [47:0] b_us_full;
    logic [31:0] d_q1, d_q2, d_elig, d_dl;
    logic        d_take;
    logic [9:0]  div_tr;
    logic        div_ge;
    logic [15:0] div_q;

    assign e_rd     = t_entry'(ram_rdata);
    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign slot_ok  = 32'(i_slot) < SLOTS;
    assign issue    = (r_state == S_SCAN) && (32'(r_idx) < SLOTS);
    assign scan_end = (r_state == S_SCAN) && !issue && !r_p1_v && !r_b_v && !r_c_v;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign cfg_wr   = psel && penable && pwrite && !paddr[2];

    assign act_st = r_vld[r_slot] ? e_rd.status : SS_FREE;
    assign p1_st  = r_vld[r_p1_idx] ? e_rd.status : SS_FREE;

    always_comb begin
        case (r_cmd)
            CMD_ADMIT:                      act_ok = (act_st == SS_FREE);
            CMD_SETATTR, CMD_SLEEP, CMD_YIELD: act_ok = (act_st == SS_RUN);
            CMD_EXIT:                       act_ok = (act_st != SS_FREE);
            default:                        act_ok = 1'b0;
        endcase
    end

    // pick arithmetic
    assign b_age_full = 35'(e_rd.weight) * 35'(r_vt - e_rd.vts);
    assign b_us_full  = 48'(e_rd.used) * 48'(r_scale);
    assign d_q1   = div_w(r_c_us, r_c_m1, r_c_e.weight);
    assign d_q2   = div_w(r_c_rs, r_c_m2, r_c_e.weight);
    assign d_elig = r_c_e.vts + d_q1;
    assign d_dl   = d_elig + d_q2;
    assign d_take = r_c_v && !r_c_lag[31] &&
                    (!r_best_f || (d_dl < r_best_dl) ||
                     ((d_dl == r_best_dl) && (r_c_e.id < r_best_e.id)));

    // one restoring-division step of scale by weight sum
    assign div_tr = {r_dr, r_dq[15]};
    assign div_ge = div_tr >= {1'b0, r_ws};
    assign div_q  = {r_dq[14:0], div_ge};

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_idx[SW-1:0];
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = e_rd;
        if (accept) begin
            ram_re    = 1'b1;
            ram_raddr = SW'(i_slot);
        end else if (issue) begin
            ram_re = 1'b1;
        end
        case (r_state)
            S_ACT: begin
                ram_we = act_ok;
                case (r_cmd)
                    CMD_ADMIT: begin
                        ram_wdata.status = SS_READY;
                        ram_wdata.id     = r_tid;
                        ram_wdata.weight = r_wgt;
                        ram_wdata.req    = r_req;
                        ram_wdata.vts    = r_vt;
                        ram_wdata.used   = 32'd0;
                        ram_wdata.chg    = 1'b0;
                    end
                    CMD_SETATTR: begin
                        ram_wdata.status = SS_READY;
                        ram_wdata.weight = r_wgt;
                        ram_wdata.req    = r_req;
                    end
                    CMD_SLEEP: begin
                        ram_wdata.status = SS_SLEEP;
                        ram_wdata.chan   = r_chan;
                    end
                    CMD_YIELD: ram_wdata.status = SS_READY;
                    default:   ram_wdata.status = SS_FREE;
                endcase
            end
            S_SCAN: begin
                ram_waddr = r_p1_idx;
                if (r_p1_v && r_cmd == CMD_WAKE && p1_st == SS_SLEEP &&
                    e_rd.chan == r_chan) begin
                    ram_we           = 1'b1;
                    ram_wdata.status = SS_READY;
                end
                if (r_p1_v && r_cmd == CMD_TICK && p1_st != SS_FREE) begin
                    ram_we        = 1'b1;
                    ram_wdata.chg = 1'b0;
                end
            end
            S_PWB: begin
                ram_we           = r_best_f;
                ram_waddr        = r_best_idx;
                ram_wdata        = r_best_e;
                ram_wdata.status = SS_RUN;
                if (!r_best_e.chg) begin
                    ram_wdata.used = r_best_e.used + 32'd1;
                    ram_wdata.chg  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_cmd'(i_command))
                        CMD_WAKE, CMD_PICK: n_state = S_SCAN;
                        CMD_TICK:           n_state = (r_ws != 9'd0) ? S_DIV : S_SCAN;
                        default:            n_state = slot_ok ? S_ACT : S_DONE;
                    endcase
                end
            end
            S_ACT:  n_state = S_DONE;
            S_DIV:  if (r_dcnt == 4'd15) n_state = S_SCAN;
            S_SCAN: if (scan_end) n_state = (r_cmd == CMD_PICK) ? S_PWB : S_DONE;
            S_PWB:  n_state = S_DONE;
            S_DONE: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= 16'd1024;
            r_vt        <= 32'd0;
            r_ws        <= 9'd0;
            r_vld       <= '0;
            r_p1_v      <= 1'b0;
            r_b_v       <= 1'b0;
            r_c_v       <= 1'b0;
            r_best_f    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) r_scale <= pwdata[15:0];
            if (ram_we) r_vld[ram_waddr] <= 1'b1;

            if (accept) begin
                r_cmd    <= t_cmd'(i_command);
                r_slot   <= SW'(i_slot);
                r_tid    <= i_task_id;
                r_wgt    <= clamp_weight(i_weight);
                r_req    <= i_request_len;
                r_chan   <= i_channel;
                r_idx    <= '0;
                r_best_f <= 1'b0;
                r_dq     <= r_scale;
                r_dr     <= 9'd0;
                r_dcnt   <= 4'd0;
                r_rst    <= slot_ok ? RES_OK : RES_BADSTATE;
                r_rcs    <= 6'd0;
                r_rcid   <= 16'd0;
            end

            if (r_state == S_ACT) begin
                r_rst <= act_ok ? RES_OK : RES_BADSTATE;
                if (act_ok) begin
                    case (r_cmd)
                        CMD_ADMIT:   r_ws <= r_ws + 9'(r_wgt);
                        CMD_SETATTR: r_ws <= r_ws - 9'(e_rd.weight) + 9'(r_wgt);
                        CMD_SLEEP:   r_ws <= r_ws - 9'(e_rd.weight);
                        CMD_EXIT: begin
                            if (act_st == SS_READY || act_st == SS_RUN)
                                r_ws <= r_ws - 9'(e_rd.weight);
                        end
                        default: ;
                    endcase
                end
            end

            if (r_state == S_DIV) begin
                r_dq   <= div_q;
                r_dr   <= div_ge ? 9'(div_tr - {1'b0, r_ws}) : div_tr[8:0];
                r_dcnt <= r_dcnt + 4'd1;
                if (r_dcnt == 4'd15)
                    r_vt <= r_vt + ((div_q == 16'd0) ? 32'd1 : 32'(div_q));
            end

            // scan pipeline: issue, RAM data, products, reciprocals, compare
            if (issue) r_idx <= r_idx + CW'(1);
            r_p1_v   <= issue;
            r_p1_idx <= r_idx[SW-1:0];
            if (r_p1_v && r_cmd == CMD_WAKE && p1_st == SS_SLEEP && e_rd.chan == r_chan)
                r_ws <= r_ws + 9'(e_rd.weight);

            r_b_v   <= r_p1_v && (r_cmd == CMD_PICK) && (p1_st == SS_READY);
            r_b_idx <= r_p1_idx;
            r_b_e   <= e_rd;
            r_b_age <= b_age_full[31:0];
            r_b_us  <= b_us_full[31:0];
            r_b_rs  <= 32'(e_rd.req) * 32'(r_scale);

            r_c_v   <= r_b_v;
            r_c_idx <= r_b_idx;
            r_c_e   <= r_b_e;
            r_c_lag <= r_b_age - r_b_us;
            r_c_us  <= r_b_us;
            r_c_rs  <= r_b_rs;
            r_c_m1  <= 64'(r_b_us) * 64'(recip(r_b_e.weight));
            r_c_m2  <= 64'(r_b_rs) * 64'(recip(r_b_e.weight));

            if (d_take) begin
                r_best_f   <= 1'b1;
                r_best_dl  <= d_dl;
                r_best_idx <= r_c_idx;
                r_best_e   <= r_c_e;
            end

            if (r_state == S_PWB) begin
                if (r_best_f) begin
                    r_rst  <= RES_OK;
                    r_rcs  <= 6'(r_best_idx);
                    r_rcid <= r_best_e.id;
                end else begin
                    r_rst <= RES_NONE;
                end
            end
            if (scan_end) r_rst <= RES_OK;

            // hold the result until taken
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_o_status  <= r_rst;
                r_o_cs      <= r_rcs;
                r_o_cid     <= r_rcid;
                r_o_vt      <= r_vt;
                r_o_ws      <= r_ws;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    eev_ram #(.DW(EW), .DEPTH(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (EW'(ram_wdata)),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_status           = r_o_status;
    assign o_chosen_slot      = r_o_cs;
    assign o_chosen_id        = r_o_cid;
    assign o_virtual_time_now = r_o_vt;
    assign o_active_weight    = r_o_ws;
    assign prdata             = paddr[2] ? 32'd0 : {16'd0, r_scale};
    assign pready             = 1'b1;
endmodule

/* src/eev_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module eev_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
